>>> src/isotp_seg_pkg.sv
// Package with the frame record type and the protocol constants of the segmenter.
`timescale 1ns / 1ps
`default_nettype none

package isotp_seg_pkg;

   localparam int unsigned CAN_ID_W    = 11;
   localparam int unsigned LEN_W       = 12;
   localparam int unsigned QUEUE_DEPTH = 2;

   // Longest PDU that still fits in a single frame.
   localparam logic [LEN_W-1:0] SF_MAX_LEN = 12'd7;
   localparam logic [3:0] FF_PAYLOAD = 4'd6;
   localparam logic [3:0] CF_PAYLOAD = 4'd7;
   localparam logic [3:0] FF_DLC     = 4'd8;

   localparam logic [7:0] PCI_FF = 8'h10;
   localparam logic [7:0] PCI_CF = 8'h20;

   // One finished CAN frame; data[0] is the protocol control byte.
   typedef struct packed {
      logic [3:0]      dlc;
      logic [7:0][7:0] data;
      logic            last;
   } frame_type;

endpackage

`default_nettype wire

>>> src/isotp_pdu_segmenter_unit.sv
// Top level of the ISO-TP transmit segmenter: PDU bytes in, classic CAN frames out.
//
//   Channel  Direction  Handshake               Beat
//   req_     in         req_valid / req_stall   one PDU byte, start flag, PDU length
//   rsp_     out        rsp_valid / rsp_stall   one CAN frame: id, DLC, 8 data bytes, last flag
//   csr_     in         csr_valid / csr_ready   target CAN identifier, 11 bits
//
// One PDU byte is accepted in every cycle unless the input is stalled; the byte that completes a frame
// reaches the result channel through a queue slot and then the output register.
// The input stalls only while the frame queue is full, so with a free-running sink the
// sustained rate is one byte per cycle, and the queue depth sets how long a stalled sink
// can be ridden out. Reset is synchronous and active high and clears all control state.
module isotp_pdu_segmenter_unit
   import isotp_seg_pkg::*;
#(
   parameter int unsigned QUEUE_SLOTS = QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_pdu_byte,
   input  wire logic                req_start_of_pdu,
   input  wire logic [LEN_W-1:0]    req_pdu_length,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CAN_ID_W-1:0]      rsp_frame_id,
   output logic [3:0]               rsp_frame_dlc,
   output logic [7:0]               rsp_data_0,
   output logic [7:0]               rsp_data_1,
   output logic [7:0]               rsp_data_2,
   output logic [7:0]               rsp_data_3,
   output logic [7:0]               rsp_data_4,
   output logic [7:0]               rsp_data_5,
   output logic [7:0]               rsp_data_6,
   output logic [7:0]               rsp_data_7,
   output logic                     rsp_last_frame,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAN_ID_W-1:0] csr_data
);

   logic [CAN_ID_W-1:0] can_id_ff;
   logic                take, push, pop, queue_full, queue_empty;
   frame_type           new_frame, head_frame, out_frame;

   // The user must change the identifier register only while the block is idle (the block
   // does not enforce it), so the output stage can stamp it on each frame as the frame leaves.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         can_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         can_id_ff <= csr_data;
      end
   end

   // A byte is held off only when a frame it might finish would have nowhere to go.
   assign req_stall = queue_full;
   assign take      = req_valid && !req_stall;

   isotp_seg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .pdu_byte     (req_pdu_byte),
      .start_of_pdu (req_start_of_pdu),
      .pdu_length   (req_pdu_length),
      .frame        (new_frame),
      .push         (push)
   );

   isotp_seg_queue #(
      .DEPTH (QUEUE_SLOTS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (new_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   isotp_seg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_frame  (head_frame),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_frame   (out_frame)
   );

   assign rsp_frame_id   = can_id_ff;
   assign rsp_frame_dlc  = out_frame.dlc;
   assign rsp_data_0     = out_frame.data[0];
   assign rsp_data_1     = out_frame.data[1];
   assign rsp_data_2     = out_frame.data[2];
   assign rsp_data_3     = out_frame.data[3];
   assign rsp_data_4     = out_frame.data[4];
   assign rsp_data_5     = out_frame.data[5];
   assign rsp_data_6     = out_frame.data[6];
   assign rsp_data_7     = out_frame.data[7];
   assign rsp_last_frame = out_frame.last;

endmodule

`default_nettype wire

>>> src/isotp_seg_front.sv
// Front end: accepts PDU bytes, tracks segmentation state and assembles whole frames.
`timescale 1ns / 1ps
`default_nettype none

module isotp_seg_front
   import isotp_seg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       pdu_byte,
   input  wire logic             start_of_pdu,
   input  wire logic [LEN_W-1:0] pdu_length,
   output frame_type             frame,
   output logic                  push
);

   logic [7:0]       bytes_ff [7];
   logic [7:0]       bytes_in [7];
   logic [2:0]       fill_ff, fill_in;
   logic [LEN_W-1:0] seen_ff, seen_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [3:0]       seq_ff, seq_in;
   logic             multi_ff, multi_in;
   logic             ffp_ff, ffp_in;

   logic [7:0]       e_bytes [7];
   logic [7:0]       w_bytes [7];
   logic [2:0]       e_fill;
   logic [LEN_W-1:0] e_seen, e_total, new_seen;
   logic [3:0]       e_seq, cap, new_fill;
   logic             e_multi, e_ffp, active, last, emit;

   always_comb begin
      // State as seen by this byte, after a start marker has reset it.
      e_bytes = bytes_ff;
      e_fill  = fill_ff;
      e_seen  = seen_ff;
      e_total = total_ff;
      e_seq   = seq_ff;
      e_multi = multi_ff;
      e_ffp   = ffp_ff;
      if (start_of_pdu) begin
         for (int i = 0; i < 7; i++) begin
            e_bytes[i] = 8'h00;
         end
         e_fill  = 3'd0;
         e_seen  = '0;
         e_total = pdu_length;
         e_seq   = 4'd1;
         e_multi = pdu_length > SF_MAX_LEN;
         e_ffp   = pdu_length > SF_MAX_LEN;
      end

      active = e_seen < e_total;
      if (!e_multi) begin
         cap = e_total[3:0];
      end else if (e_ffp) begin
         cap = FF_PAYLOAD;
      end else begin
         cap = CF_PAYLOAD;
      end

      new_fill = {1'b0, e_fill} + 4'd1;
      new_seen = e_seen + LEN_W'(1);
      last     = new_seen >= e_total;
      emit     = active && ((new_fill >= cap) || last);

      w_bytes = e_bytes;
      for (int i = 0; i < 7; i++) begin
         if (active && (e_fill == 3'(i))) begin
            w_bytes[i] = pdu_byte;
         end
      end

      bytes_in = w_bytes;
      fill_in  = active ? new_fill[2:0] : e_fill;
      seen_in  = active ? new_seen : e_seen;
      total_in = e_total;
      seq_in   = e_seq;
      multi_in = e_multi;
      ffp_in   = e_ffp;

      frame.last = last;
      frame.data = '0;
      if (!e_multi) begin
         frame.dlc     = new_fill + 4'd1;
         frame.data[0] = {4'h0, e_total[3:0]};
         for (int i = 0; i < 7; i++) begin
            frame.data[i+1] = w_bytes[i];
         end
      end else if (e_ffp) begin
         frame.dlc     = FF_DLC;
         frame.data[0] = PCI_FF | {4'h0, e_total[11:8]};
         frame.data[1] = e_total[7:0];
         for (int i = 0; i < 6; i++) begin
            frame.data[i+2] = w_bytes[i];
         end
      end else begin
         frame.dlc     = new_fill + 4'd1;
         frame.data[0] = PCI_CF | {4'h0, e_seq};
         for (int i = 0; i < 7; i++) begin
            frame.data[i+1] = w_bytes[i];
         end
      end

      if (emit) begin
         for (int i = 0; i < 7; i++) begin
            bytes_in[i] = 8'h00;
         end
         fill_in = 3'd0;
         ffp_in  = 1'b0;
         if (e_multi && e_ffp) begin
            seq_in = 4'd1;
         end else if (e_multi) begin
            seq_in = e_seq + 4'd1;
         end
      end

      push = take && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) begin
            bytes_ff[i] <= 8'h00;
         end
         fill_ff  <= 3'd0;
         seen_ff  <= '0;
         total_ff <= '0;
         seq_ff   <= 4'd1;
         multi_ff <= 1'b0;
         ffp_ff   <= 1'b0;
      end else if (take) begin
         bytes_ff <= bytes_in;
         fill_ff  <= fill_in;
         seen_ff  <= seen_in;
         total_ff <= total_in;
         seq_ff   <= seq_in;
         multi_ff <= multi_in;
         ffp_ff   <= ffp_in;
      end
   end

endmodule

`default_nettype wire

>>> src/isotp_seg_queue.sv
// Short frame queue between the assembling front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module isotp_seg_queue
   import isotp_seg_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_frame,
   input  wire logic      pop,
   output frame_type      head_frame,
   output logic           full,
   output logic           empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   frame_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign empty      = count_ff == '0;
   assign head_frame = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/isotp_seg_back.sv
// Back end: output register that presents queued frames on the result channel.
`timescale 1ns / 1ps
`default_nettype none

module isotp_seg_back
   import isotp_seg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                queue_empty,
   input  wire frame_type           head_frame,
   output logic                     pop,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output frame_type                rsp_frame
);

   logic      valid_ff, valid_in;
   frame_type frame_ff;

   // The output register reloads whenever it is empty or its beat is taken.
   assign pop       = !queue_empty && (!valid_ff || !rsp_stall);
   assign valid_in  = pop ? 1'b1 : (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_frame = frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_ff <= head_frame;
      end
   end

endmodule

`default_nettype wire
